/* hw/rtl/base64_stream_encoder_defines.svh */
// assertion macros shared by the base64 stream encoder rtl
// no dependencies; included by the files that carry assertions
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

// condition holds at every clock outside reset
`define B64E_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the same cycle
`define B64E_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent in one cycle implies consequent in the next cycle
`define B64E_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/b64e_pkg.sv */
// types, constants and the alphabet lookup of the base64 stream encoder
// no dependencies; used by every module of the block
package b64e_pkg;

   localparam logic [7:0] PAD_CHAR = 8'd61;

   typedef logic [1:0] slot_type;
   localparam slot_type SLOT_FIRST  = 2'd0;
   localparam slot_type SLOT_SECOND = 2'd1;
   localparam slot_type SLOT_THIRD  = 2'd2;
   localparam slot_type SLOT_FOURTH = 2'd3;

   // one accepted byte turned into up to four characters
   typedef struct packed {
      logic [3:0][5:0] sym;       // six-bit alphabet indexes
      logic [3:0]      pad;       // slot is an '=' pad
      slot_type        last_slot; // final slot of this byte
      logic            fin;       // byte ended the message
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_status_type;

   function automatic logic [7:0] b64e_alphabet(input logic [5:0] idx);
      logic [7:0] code;
      code = {2'b00, idx};
      if (idx < 6'd26) begin
         b64e_alphabet = code + 8'd65;
      end else if (idx < 6'd52) begin
         b64e_alphabet = code + 8'd71;
      end else if (idx < 6'd62) begin
         b64e_alphabet = code - 8'd4;
      end else if (idx == 6'd62) begin
         b64e_alphabet = 8'd43;
      end else begin
         b64e_alphabet = 8'd47;
      end
   endfunction

endpackage

/* hw/rtl/b64e_if.sv */
// valid/ready channel interfaces for message bytes and encoded characters
// no dependencies
interface b64e_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_message;

   modport source (output valid, output data_byte, output end_of_message, input ready);
   modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64e_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] ascii_char;
   logic       last_char;

   modport source (output valid, output ascii_char, output last_char, input ready);
   modport sink (input valid, input ascii_char, input last_char, output ready);
endinterface

/* hw/rtl/b64e_front.sv */
// front end: takes message bytes, tracks the group position, builds character jobs
// depends on b64e_pkg and b64e_req_if
module b64e_front (
   input  logic               clock,
   input  logic               reset,
   b64e_req_if.sink           req_if,
   output b64e_pkg::job_type  job,
   output logic               job_valid,
   input  logic               job_ready
);
   import b64e_pkg::*;

   typedef enum logic [1:0] {
      POS_FIRST  = 2'd0,
      POS_SECOND = 2'd1,
      POS_THIRD  = 2'd2
   } pos_type;

   pos_type    pos_ff, pos_in;
   logic [3:0] left_ff, left_in;
   logic [7:0] b;
   logic       fin;
   logic       take;

   assign req_if.ready = job_ready;
   assign job_valid    = req_if.valid;
   assign take         = req_if.valid & job_ready;
   assign b            = req_if.data_byte;
   assign fin          = req_if.end_of_message;

   always_comb begin
      job     = '0;
      job.fin = fin;
      pos_in  = POS_FIRST;
      left_in = 4'd0;
      case (pos_ff)
         POS_SECOND: begin
            job.sym[0]    = {left_ff[1:0], b[7:4]};
            job.sym[1]    = {b[3:0], 2'b00};
            job.last_slot = fin ? SLOT_THIRD : SLOT_FIRST;
            if (fin) begin
               job.pad[2] = 1'b1;
            end else begin
               pos_in  = POS_THIRD;
               left_in = b[3:0];
            end
         end
         POS_THIRD: begin
            job.sym[0]    = {left_ff, b[7:6]};
            job.sym[1]    = b[5:0];
            job.last_slot = SLOT_SECOND;
         end
         default: begin
            job.sym[0]    = b[7:2];
            job.sym[1]    = {b[1:0], 4'b0000};
            job.last_slot = fin ? SLOT_FOURTH : SLOT_FIRST;
            if (fin) begin
               job.pad[2] = 1'b1;
               job.pad[3] = 1'b1;
            end else begin
               pos_in  = POS_SECOND;
               left_in = {2'b00, b[1:0]};
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= POS_FIRST;
         left_ff <= 4'd0;
      end else if (take) begin
         pos_ff  <= pos_in;
         left_ff <= left_in;
      end
   end

endmodule

/* hw/rtl/b64e_fifo.sv */
// short job queue between the front end and the character emitter
// depends on b64e_pkg
module b64e_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  b64e_pkg::job_type         push_job,
   input  logic                      push,
   input  logic                      pop,
   output b64e_pkg::job_type         head_job,
   output b64e_pkg::fifo_status_type status
);
   import b64e_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]   count_ff;
   logic             do_push, do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == (PTR_W+1)'(DEPTH));
   assign do_push      = push & ~status.full;
   assign do_pop       = pop & ~status.empty;
   assign head_job     = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

/* hw/rtl/b64e_back.sv */
// back end: steps through the slots of each job, one character per cycle while a
// job is queued and the sink is ready; depends on b64e_pkg and b64e_rsp_if
module b64e_back (
   input  logic              clock,
   input  logic              reset,
   input  b64e_pkg::job_type head_job,
   input  logic              head_valid,
   output logic              head_pop,
   b64e_rsp_if.source        rsp_if
);
   import b64e_pkg::*;

   slot_type   slot_ff;
   logic       out_valid_ff;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       load;
   logic       slot_done;

   assign load      = head_valid & (~out_valid_ff | rsp_if.ready);
   assign slot_done = (slot_ff == head_job.last_slot);
   assign head_pop  = load & slot_done;

   always_comb begin
      char_in = head_job.pad[slot_ff] ? PAD_CHAR : b64e_alphabet(head_job.sym[slot_ff]);
      last_in = slot_done & head_job.fin;
   end

   // output register: next character loads while the current one is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= SLOT_FIRST;
         out_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            out_valid_ff <= 1'b1;
            slot_ff      <= slot_done ? SLOT_FIRST : slot_ff + 1'b1;
         end else if (rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= char_in;
         last_ff <= last_in;
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.ascii_char = char_ff;
   assign rsp_if.last_char  = last_ff;

endmodule

/* hw/rtl/base64_stream_encoder.sv */
// channel   | dir | payload                      | handshake
// req_if    | in  | data_byte, end_of_message    | valid/ready
// rsp_if    | out | ascii_char, last_char        | valid/ready
//
// one character leaves per cycle from the back end's output register while jobs
// are queued and the sink is ready; a byte makes one or two characters and a
// final byte up to four; a full group of three bytes makes four characters and
// a one-byte message four, all through the single character path of the back end.
// bytes enter back to back while the job queue has room. reset is synchronous
// and clears the group position, the queue and the output register's valid flag.
// depends on b64e_pkg, b64e_if, b64e_front, b64e_fifo, b64e_back
module base64_stream_encoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   b64e_req_if.sink    req_if,
   b64e_rsp_if.source  rsp_if
);
   import b64e_pkg::*;
   `include "base64_stream_encoder_defines.svh"

   job_type         front_job;
   logic            front_valid;
   job_type         head_job;
   logic            head_pop;
   fifo_status_type q_status;

   b64e_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .job       (front_job),
      .job_valid (front_valid),
      .job_ready (~q_status.full)
   );

   b64e_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push_job (front_job),
      .push     (front_valid),
      .pop      (head_pop),
      .head_job (head_job),
      .status   (q_status)
   );

   b64e_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .head_valid (~q_status.empty),
      .head_pop   (head_pop),
      .rsp_if     (rsp_if)
   );

   `B64E_ASSERT_ALWAYS(a_queue_state, clock, reset, !(q_status.full && q_status.empty), "queue both full and empty")
   `B64E_ASSERT_IMPLIES(a_pad_slots, clock, reset, front_valid && front_job.pad[3], front_job.fin && front_job.last_slot == SLOT_FOURTH, "double pad without final slot four")
   `B64E_ASSERT_NEXT(a_pop_emits, clock, reset, head_pop, rsp_if.valid, "job slot popped without a character")

endmodule

/* verif/base64_stream_encoder_tb.sv */
// testbench for base64_stream_encoder: a directed table, then random messages
// with random idling on both channels outside the quiet run, checked against a behavioral encoder
// depends on b64e_pkg, b64e_if and base64_stream_encoder
module base64_stream_encoder_tb;
   import b64e_pkg::*;

   localparam int CYCLE_LIMIT = 250000;
   localparam int HOLD_CYCLES = 150;
   localparam int TAIL_CYCLES = 24;
   localparam int DIRECTED_ROWS = 25;

   localparam logic [0:63][7:0] B64_SYMBOLS =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } enc_char_type;

   // a row with n_typed of zero is checked against the encoder model alone
   typedef struct packed {
      logic [7:0]  data;
      logic        eom;
      logic [2:0]  n_typed;
      logic [31:0] typed;
   } stim_row_type;

   logic clock;
   logic reset;

   b64e_req_if req_chan ();
   b64e_rsp_if rsp_chan ();

   base64_stream_encoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{8'h00, 1'b1, 3'd4, "AA=="},
      '{8'hFF, 1'b1, 3'd4, "/w=="},
      '{8'hFF, 1'b0, 3'd1, "/"},
      '{8'hFF, 1'b0, 3'd1, "/"},
      '{8'hFF, 1'b1, 3'd2, "//"},
      '{8'h00, 1'b0, 3'd1, "A"},
      '{8'h00, 1'b1, 3'd3, "AA="},
      '{8'h4D, 1'b0, 3'd1, "T"},
      '{8'h61, 1'b0, 3'd1, "W"},
      '{8'h6E, 1'b0, 3'd2, "Fu"},
      '{8'hAA, 1'b1, 3'd4, "qg=="},
      '{8'hFF, 1'b0, 3'd1, "/"},
      '{8'hFF, 1'b1, 3'd3, "/8="},
      '{8'h00, 1'b0, 3'd1, "A"},
      '{8'h00, 1'b0, 3'd1, "A"},
      '{8'h00, 1'b1, 3'd2, "AA"},
      '{8'h80, 1'b0, 3'd0, 32'd0},
      '{8'h01, 1'b0, 3'd0, 32'd0},
      '{8'h7F, 1'b0, 3'd0, 32'd0},
      '{8'h55, 1'b0, 3'd0, 32'd0},
      '{8'h0F, 1'b1, 3'd0, 32'd0},
      '{8'hC3, 1'b0, 3'd0, 32'd0},
      '{8'h3C, 1'b0, 3'd0, 32'd0},
      '{8'h5A, 1'b1, 3'd0, 32'd0},
      '{8'h81, 1'b1, 3'd0, 32'd0}
   };

   slot_type     group_slot = SLOT_FIRST;
   logic [3:0]   carry_bits = 4'd0;
   enc_char_type fresh_chars [$];
   enc_char_type expected_chars [$];
   stim_row_type typed_notes [$];
   int           mismatch_count = 0;
   int           cycle_count = 0;
   int           stall_orders = 0;
   int           stalls_served = 0;
   int           hold_left = 0;
   logic         quiet = 1'b0;

   always #6 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("mismatch at cycle %0d: %s got 0x%02h expected 0x%02h",
               cycle_count, what, got, want);
      mismatch_count++;
   endtask

   // encoder state advance for one byte; characters land in fresh_chars
   function automatic void predict_chars(input logic [7:0] b, input logic eom);
      case (group_slot)
         SLOT_SECOND: begin
            fresh_chars.push_back('{B64_SYMBOLS[{carry_bits[1:0], b[7:4]}], 1'b0});
            if (eom) begin
               fresh_chars.push_back('{B64_SYMBOLS[{b[3:0], 2'b00}], 1'b0});
               fresh_chars.push_back('{PAD_CHAR, 1'b1});
               group_slot = SLOT_FIRST;
               carry_bits = 4'd0;
            end else begin
               group_slot = SLOT_THIRD;
               carry_bits = b[3:0];
            end
         end
         SLOT_THIRD: begin
            fresh_chars.push_back('{B64_SYMBOLS[{carry_bits, b[7:6]}], 1'b0});
            fresh_chars.push_back('{B64_SYMBOLS[b[5:0]], eom});
            group_slot = SLOT_FIRST;
            carry_bits = 4'd0;
         end
         default: begin
            fresh_chars.push_back('{B64_SYMBOLS[b[7:2]], 1'b0});
            if (eom) begin
               fresh_chars.push_back('{B64_SYMBOLS[{b[1:0], 4'b0000}], 1'b0});
               fresh_chars.push_back('{PAD_CHAR, 1'b0});
               fresh_chars.push_back('{PAD_CHAR, 1'b1});
               group_slot = SLOT_FIRST;
               carry_bits = 4'd0;
            end else begin
               group_slot = SLOT_SECOND;
               carry_bits = {2'b00, b[1:0]};
            end
         end
      endcase
   endfunction

   // byte transfers are predicted before character transfers are checked
   always @(posedge clock) begin
      stim_row_type note;
      enc_char_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("base64_stream_encoder verification failed");
         $finish;
      end else if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            note = typed_notes.pop_front();
            fresh_chars.delete();
            predict_chars(req_chan.data_byte, req_chan.end_of_message);
            if (note.n_typed != 3'd0) begin
               for (int k = 0; k < note.n_typed; k++) begin
                  expected_chars.push_back('{note.typed[8*(note.n_typed-1-k) +: 8],
                                             note.eom && (k == note.n_typed - 1)});
               end
            end else begin
               foreach (fresh_chars[k]) expected_chars.push_back(fresh_chars[k]);
            end
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_chars.size() == 0) begin
               report_mismatch("unexpected character", rsp_chan.ascii_char, 8'd0);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_chan.ascii_char !== want.code)
                  report_mismatch("ascii_char", rsp_chan.ascii_char, want.code);
               if (rsp_chan.last_char !== want.last)
                  report_mismatch("last_char", {7'd0, rsp_chan.last_char},
                                  {7'd0, want.last});
            end
         end
      end
   end

   // character sink: random back-pressure, long holds on request, always ready while quiet
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_orders != stalls_served) begin
            stalls_served = stalls_served + 1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left = hold_left - 1;
         end else if (quiet) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= 24);
         end
      end
   end

   task automatic offer_byte(input stim_row_type row);
      while (!quiet && $urandom_range(99) < 24) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      typed_notes.push_back(row);
      req_chan.valid          <= 1'b1;
      req_chan.data_byte      <= row.data;
      req_chan.end_of_message <= row.eom;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (expected_chars.size() != 0 || typed_notes.size() != 0);
   endtask

   // random messages until byte_budget bytes have been sent
   task automatic run_messages(input int byte_budget, input int stall_at);
      stim_row_type row;
      int msg_len;
      int pick;
      int sent;
      sent = 0;
      while (sent < byte_budget) begin
         pick = $urandom_range(99);
         if (pick < 80) msg_len = $urandom_range(9, 1);
         else if (pick < 95) msg_len = $urandom_range(30, 10);
         else msg_len = 1;
         for (int k = 0; k < msg_len && sent < byte_budget; k++) begin
            pick = $urandom_range(99);
            row.data = (pick < 5) ? 8'h00 : (pick < 10) ? 8'hFF : 8'($urandom_range(255));
            row.eom = (k == msg_len - 1) || (sent == byte_budget - 1);
            row.n_typed = 3'd0;
            row.typed = 32'd0;
            if (sent == stall_at) stall_orders <= stall_orders + 1;
            offer_byte(row);
            sent++;
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_chan.valid          <= 1'b0;
      req_chan.data_byte      <= 8'd0;
      req_chan.end_of_message <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) offer_byte(directed_rows[r]);
      wait_drained();

      run_messages(150, 60);
      quiet <= 1'b1;
      run_messages(100, -1);
      quiet <= 1'b0;
      wait_drained();
      run_messages(155, 40);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_chars.size() != 0)
         report_mismatch("characters never sent", 8'(expected_chars.size()), 8'd0);
      if (mismatch_count == 0) begin
         $display("base64_stream_encoder verification clean");
      end else begin
         $display("base64_stream_encoder verification failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/b64e_pkg.sv
hw/rtl/b64e_if.sv
hw/rtl/b64e_front.sv
hw/rtl/b64e_fifo.sv
hw/rtl/b64e_back.sv
hw/rtl/base64_stream_encoder.sv
verif/base64_stream_encoder_tb.sv
